@@ hdl/cbps_pkg.sv @@
// Shared types, constants and codes for the CPU busy-share sampler.
package cbps_pkg;

   localparam int TIME_BITS_DEFAULT = 48;
   localparam int NOW_W             = 48;
   localparam int TICK_W            = 64;
   localparam int INTERVAL_W        = 16;
   localparam int USAGE_W           = 14;
   localparam int KIND_W            = 3;
   localparam int SCALE_W           = 14;
   localparam int PROD_W            = TICK_W + SCALE_W;
   localparam int QUOT_W            = 14;
   localparam int DIV_CNT_W         = $clog2(QUOT_W);

   localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RESET = INTERVAL_W'(100);
   localparam logic [SCALE_W-1:0]    FULL_SCALE         = SCALE_W'(10000);

   typedef enum logic [KIND_W-1:0] {
      KIND_FRESH         = 3'd0,
      KIND_HELD_INTERVAL = 3'd1,
      KIND_HELD_READ     = 3'd2,
      KIND_BASELINE      = 3'd3,
      KIND_HELD_ZERO     = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [NOW_W-1:0]  now_ms;
      logic [TICK_W-1:0] idle_ticks;
      logic [TICK_W-1:0] kernel_ticks;
      logic [TICK_W-1:0] user_ticks;
      logic              read_ok;
   } req_type;

   typedef struct packed {
      logic [USAGE_W-1:0] usage_centi_pct;
      logic [KIND_W-1:0]  result_kind;
   } rsp_type;

   typedef struct packed {
      logic     capture;
      logic     commit;
      logic     held_clear;
      logic     mul_load;
      logic     div_step;
      logic     held_quot;
      logic     result_load;
      kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic has_baseline;
      logic interval_short;
      logic read_ok;
      logic dtotal_zero;
      logic idle_over;
      logic div_last;
   } status_type;

endpackage

@@ hdl/cbps_dp.sv @@
// Sampler datapath: sample capture, baseline, deltas, scaling multiply and divider.
module cbps_dp #(
   parameter int TIME_BITS = cbps_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cbps_pkg::req_type                   req_data,
   input  logic                                csr_wr_en,
   input  logic [cbps_pkg::INTERVAL_W-1:0]     csr_wr_data,
   input  cbps_pkg::cmd_type                   cmd,
   output cbps_pkg::status_type                status,
   output cbps_pkg::rsp_type                   rsp_data
);

   localparam int TW = cbps_pkg::TICK_W;
   localparam int QW = cbps_pkg::QUOT_W;
   localparam int PW = cbps_pkg::PROD_W;

   logic [cbps_pkg::INTERVAL_W-1:0] min_interval_ff;
   logic [TIME_BITS-1:0]            now_ff;
   logic [TW-1:0]                   idle_ff;
   logic [TW-1:0]                   total_ff;
   logic                            ok_ff;
   logic                            has_baseline_ff;
   logic [TIME_BITS-1:0]            base_time_ff;
   logic [TW-1:0]                   base_idle_ff;
   logic [TW-1:0]                   base_total_ff;
   logic [cbps_pkg::USAGE_W-1:0]    held_ff;
   logic [TW-1:0]                   dtotal_ff;
   logic [TW-1:0]                   busy_ff;
   logic [TW-1:0]                   rem_ff;
   logic [QW-1:0]                   quot_ff;
   logic [cbps_pkg::DIV_CNT_W-1:0]  cnt_ff;
   cbps_pkg::rsp_type               rsp_ff;

   logic [TIME_BITS-1:0] elapsed;
   logic [TW-1:0]        dtotal;
   logic [TW-1:0]        didle;
   logic [PW-1:0]        product;
   logic [TW:0]          trial;
   logic                 ge;
   logic [TW:0]          diff;
   logic [QW-1:0]        quot_in;
   cbps_pkg::rsp_type    rsp_in;

   assign elapsed = now_ff - base_time_ff;
   assign dtotal  = total_ff - base_total_ff;
   assign didle   = idle_ff - base_idle_ff;
   assign product = PW'(busy_ff) * PW'(cbps_pkg::FULL_SCALE);
   assign trial   = {rem_ff, quot_ff[QW-1]};
   assign ge      = trial >= {1'b0, dtotal_ff};
   assign diff    = trial - {1'b0, dtotal_ff};
   assign quot_in = {quot_ff[QW-2:0], ge};

   assign status.has_baseline   = has_baseline_ff;
   assign status.interval_short = elapsed < TIME_BITS'(min_interval_ff);
   assign status.read_ok        = ok_ff;
   assign status.dtotal_zero    = (dtotal == '0);
   assign status.idle_over      = didle > dtotal;
   assign status.div_last       = (cnt_ff == '0);

   always_comb begin
      rsp_in.result_kind = cmd.kind;
      if (cmd.kind == cbps_pkg::KIND_BASELINE) begin
         rsp_in.usage_centi_pct = '0;
      end else begin
         rsp_in.usage_centi_pct = held_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_interval_ff <= cbps_pkg::MIN_INTERVAL_RESET;
         has_baseline_ff <= 1'b0;
         held_ff         <= '0;
      end else begin
         if (csr_wr_en) begin
            min_interval_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            has_baseline_ff <= 1'b1;
         end
         if (cmd.held_clear) begin
            held_ff <= '0;
         end else if (cmd.held_quot) begin
            held_ff <= quot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff   <= TIME_BITS'(req_data.now_ms);
         idle_ff  <= req_data.idle_ticks;
         total_ff <= req_data.kernel_ticks + req_data.user_ticks;
         ok_ff    <= req_data.read_ok;
      end
      if (cmd.commit) begin
         base_time_ff  <= now_ff;
         base_idle_ff  <= idle_ff;
         base_total_ff <= total_ff;
         dtotal_ff     <= dtotal;
         busy_ff       <= dtotal - didle;
      end
      if (cmd.mul_load) begin
         rem_ff  <= product[PW-1:QW];
         quot_ff <= product[QW-1:0];
         cnt_ff  <= cbps_pkg::DIV_CNT_W'(QW - 1);
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? diff[TW-1:0] : trial[TW-1:0];
         quot_ff <= quot_in;
         cnt_ff  <= cnt_ff - 1'b1;
      end
      if (cmd.result_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ hdl/cbps_ctrl.sv @@
// Sampler controller: sequences evaluate, multiply, divide and result transfer.
module cbps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  cbps_pkg::status_type status,
   output cbps_pkg::cmd_type    cmd
);

   cbps_pkg::state_type state_ff, state_in;
   cbps_pkg::kind_type  kind_ff, kind_in;
   logic                rsp_valid_ff;
   logic                slot_free;
   logic                take;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign take      = status.read_ok && !(status.has_baseline && status.interval_short);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cbps_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cbps_pkg::ST_EVAL;
            end
         end
         cbps_pkg::ST_EVAL: begin
            if (take && status.has_baseline && !status.dtotal_zero && !status.idle_over) begin
               state_in = cbps_pkg::ST_MUL;
            end else begin
               state_in = cbps_pkg::ST_DONE;
            end
         end
         cbps_pkg::ST_MUL: begin
            state_in = cbps_pkg::ST_DIV;
         end
         cbps_pkg::ST_DIV: begin
            if (status.div_last) begin
               state_in = cbps_pkg::ST_DONE;
            end
         end
         cbps_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = cbps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cbps_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.kind    = kind_ff;
      kind_in     = kind_ff;
      case (state_ff)
         cbps_pkg::ST_IDLE: begin
            cmd.capture = req_valid;
         end
         cbps_pkg::ST_EVAL: begin
            if (status.has_baseline && status.interval_short) begin
               kind_in = cbps_pkg::KIND_HELD_INTERVAL;
            end else if (!status.read_ok) begin
               kind_in = cbps_pkg::KIND_HELD_READ;
            end else begin
               cmd.commit = 1'b1;
               if (!status.has_baseline) begin
                  kind_in = cbps_pkg::KIND_BASELINE;
               end else if (status.dtotal_zero) begin
                  kind_in = cbps_pkg::KIND_HELD_ZERO;
               end else begin
                  kind_in        = cbps_pkg::KIND_FRESH;
                  cmd.held_clear = status.idle_over;
               end
            end
         end
         cbps_pkg::ST_MUL: begin
            cmd.mul_load = 1'b1;
         end
         cbps_pkg::ST_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.held_quot = status.div_last;
         end
         cbps_pkg::ST_DONE: begin
            cmd.result_load = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbps_pkg::ST_IDLE;
         kind_ff      <= cbps_pkg::KIND_FRESH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         if (cmd.result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = (state_ff != cbps_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/cpu_busy_percent_sampler_core.sv @@
// A held, baseline or clamped result goes from evaluate straight to the output register;
// a divided fresh result first passes evaluate, multiply and a 14-step restoring divider.
// The input side stalls until the previous sample's result has reached the output register.
// The result sits in an output register, so the next sample is taken while it waits.
// Synchronous active-high reset clears the baseline flag, held usage, the output
// valid and sets min_interval_ms to 100.
module cpu_busy_percent_sampler_core #(
   parameter int TIME_BITS = cbps_pkg::TIME_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  cbps_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output cbps_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [cbps_pkg::INTERVAL_W-1:0] csr_wr_data
);

   cbps_pkg::cmd_type    cmd;
   cbps_pkg::status_type status;

   cbps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cbps_dp #(
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_data    (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input side not busy after transfer");

   a_usage_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.usage_centi_pct <= cbps_pkg::USAGE_W'(cbps_pkg::FULL_SCALE))
      else $error("usage above full scale");

   a_baseline_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == cbps_pkg::KIND_BASELINE
      |-> rsp_data.usage_centi_pct == '0)
      else $error("baseline result with nonzero usage");
`endif

endmodule

@@ test/cpu_busy_percent_sampler_core_tb.sv @@
// Self-checking testbench for the CPU busy-share sampler core.
`timescale 1ns / 1ps

module cpu_busy_percent_sampler_core_tb;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   cbps_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   cbps_pkg::rsp_type               rsp_data;
   logic                            csr_wr_en = 1'b0;
   logic [cbps_pkg::INTERVAL_W-1:0] csr_wr_data = '0;

   // busy-share prediction state
   logic                            has_baseline = 1'b0;
   logic [cbps_pkg::NOW_W-1:0]      base_time = '0;
   logic [cbps_pkg::TICK_W-1:0]     base_idle = '0;
   logic [cbps_pkg::TICK_W-1:0]     base_total = '0;
   logic [cbps_pkg::USAGE_W-1:0]    held_usage = '0;
   logic [cbps_pkg::INTERVAL_W-1:0] min_interval = cbps_pkg::MIN_INTERVAL_RESET;

   // counters of the synthetic load generator
   logic [cbps_pkg::NOW_W-1:0]      load_now = '0;
   logic [cbps_pkg::TICK_W-1:0]     load_idle = '0;
   logic [cbps_pkg::TICK_W-1:0]     load_kernel = '0;
   logic [cbps_pkg::TICK_W-1:0]     load_user = '0;

   cbps_pkg::rsp_type               pending_readings[$];
   int                              sender_idle_pct = 0;
   int                              receiver_stall_pct = 0;
   int                              error_count = 0;
   int                              samples_sent = 0;
   int                              readings_checked = 0;
   int                              interval_settings = 1;
   int                              kind_seen[8] = '{default: 0};

   cpu_busy_percent_sampler_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   initial begin
      #(5_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic cbps_pkg::rsp_type predict_busy_share(input cbps_pkg::req_type s);
      cbps_pkg::rsp_type           r;
      logic [cbps_pkg::NOW_W-1:0]  elapsed;
      logic [cbps_pkg::TICK_W-1:0] total;
      logic [cbps_pkg::TICK_W-1:0] d_idle;
      logic [cbps_pkg::TICK_W-1:0] d_total;
      logic [cbps_pkg::TICK_W-1:0] busy;
      logic [127:0]                scaled;
      logic                        had;
      total   = s.kernel_ticks + s.user_ticks;
      elapsed = s.now_ms - base_time;
      if (has_baseline && elapsed < min_interval) begin
         r.usage_centi_pct = held_usage;
         r.result_kind     = cbps_pkg::KIND_HELD_INTERVAL;
      end else if (!s.read_ok) begin
         r.usage_centi_pct = held_usage;
         r.result_kind     = cbps_pkg::KIND_HELD_READ;
      end else begin
         had          = has_baseline;
         d_idle       = s.idle_ticks - base_idle;
         d_total      = total - base_total;
         has_baseline = 1'b1;
         base_time    = s.now_ms;
         base_idle    = s.idle_ticks;
         base_total   = total;
         if (!had) begin
            r.usage_centi_pct = '0;
            r.result_kind     = cbps_pkg::KIND_BASELINE;
         end else if (d_total == '0) begin
            r.usage_centi_pct = held_usage;
            r.result_kind     = cbps_pkg::KIND_HELD_ZERO;
         end else begin
            if (d_idle > d_total) begin
               held_usage = '0;
            end else begin
               busy   = d_total - d_idle;
               scaled = {64'd0, busy} * 128'd10000 / {64'd0, d_total};
               held_usage = (scaled > 128'd10000) ? cbps_pkg::FULL_SCALE
                                                  : scaled[cbps_pkg::USAGE_W-1:0];
            end
            r.usage_centi_pct = held_usage;
            r.result_kind     = cbps_pkg::KIND_FRESH;
         end
      end
      return r;
   endfunction

   function automatic cbps_pkg::req_type sample_of(input logic [cbps_pkg::NOW_W-1:0] now,
                                                   input logic [cbps_pkg::TICK_W-1:0] idle,
                                                   input logic [cbps_pkg::TICK_W-1:0] kernel,
                                                   input logic [cbps_pkg::TICK_W-1:0] user,
                                                   input logic ok);
      cbps_pkg::req_type s;
      s.now_ms       = now;
      s.idle_ticks   = idle;
      s.kernel_ticks = kernel;
      s.user_ticks   = user;
      s.read_ok      = ok;
      return s;
   endfunction

   function automatic logic [cbps_pkg::TICK_W-1:0] tick_delta();
      int pick;
      pick = $urandom_range(99, 0);
      if (pick < 20) return '0;
      if (pick < 90) return cbps_pkg::TICK_W'($urandom_range(100000, 0));
      return {$urandom, $urandom};
   endfunction

   function automatic cbps_pkg::req_type next_load_sample();
      int                          pick;
      logic [cbps_pkg::TICK_W-1:0] d_idle;
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
         // inject raw noise across all bits
         load_now    = cbps_pkg::NOW_W'({$urandom, $urandom});
         load_idle   = {$urandom, $urandom};
         load_kernel = {$urandom, $urandom};
         load_user   = {$urandom, $urandom};
      end else begin
         pick = $urandom_range(99, 0);
         if (pick < 25)
            load_now = load_now
                     + cbps_pkg::NOW_W'($urandom_range(int'(min_interval), 0));
         else if (pick < 90)
            load_now = load_now + cbps_pkg::NOW_W'(min_interval)
                     + cbps_pkg::NOW_W'($urandom_range(200, 0));
         else
            load_now = load_now + cbps_pkg::NOW_W'($urandom);
         if ($urandom_range(99, 0) >= 5) begin
            d_idle      = tick_delta();
            load_idle   = load_idle + d_idle;
            load_kernel = load_kernel + d_idle + tick_delta();
            load_user   = load_user + tick_delta();
            if ($urandom_range(99, 0) < 5)
               load_idle = load_idle + cbps_pkg::TICK_W'($urandom_range(5000, 1));
         end
      end
      return sample_of(load_now, load_idle, load_kernel, load_user,
                       $urandom_range(99, 0) >= 10);
   endfunction

   task automatic send_sample(input cbps_pkg::req_type s);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (req_stall);
      pending_readings.push_back(predict_busy_share(s));
      samples_sent++;
   endtask

   task automatic drain_readings();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_min_interval(input logic [cbps_pkg::INTERVAL_W-1:0] value);
      drain_readings();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      min_interval  = value;
      interval_settings++;
   endtask

   always @(posedge clock) begin : check_readings
      cbps_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         readings_checked++;
         kind_seen[rsp_data.result_kind]++;
         if (pending_readings.size() == 0) begin
            $error("unexpected transfer: usage_centi_pct %0d result_kind %0d",
                   rsp_data.usage_centi_pct, rsp_data.result_kind);
            error_count++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_data.usage_centi_pct !== want.usage_centi_pct) begin
               $error("usage_centi_pct: expected %0d, got %0d",
                      want.usage_centi_pct, rsp_data.usage_centi_pct);
               error_count++;
            end
            if (rsp_data.result_kind !== want.result_kind) begin
               $error("result_kind: expected %0d, got %0d",
                      want.result_kind, rsp_data.result_kind);
               error_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
   end

   task automatic test_directed_cases();
      logic [cbps_pkg::TICK_W-1:0] ones;
      ones = '1;
      send_sample(sample_of(48'd0, 64'd0, 64'd0, 64'd0, 1'b0));
      send_sample(sample_of(48'd0, 64'd0, 64'd0, 64'd0, 1'b1));
      send_sample(sample_of(48'd99, 64'd0, 64'd0, 64'd0, 1'b1));
      send_sample(sample_of(48'd100, 64'd0, 64'd0, 64'd0, 1'b1));
      send_sample(sample_of(48'd200, 64'd0, 64'd1000, 64'd0, 1'b1));
      send_sample(sample_of(48'd300, 64'd1000, 64'd2000, 64'd0, 1'b1));
      send_sample(sample_of(48'd400, 64'd3000, 64'd2500, 64'd0, 1'b1));
      send_sample(sample_of(48'd500, 64'd3001, 64'd2501, 64'd2, 1'b1));
      send_sample(sample_of(48'd600, 64'd3001, 64'd2501, 64'd2, 1'b0));
      send_sample(sample_of(48'd700, 64'h8000_0000_0000_0000, ones, 64'h10, 1'b1));
      send_sample(sample_of(48'd800, ones, ones, ones, 1'b1));
      send_sample(sample_of(48'd900, 64'd0, 64'd0, 64'd0, 1'b1));
      send_sample(sample_of(48'hFFFF_FFFF_FFCE, 64'd1, 64'd5, 64'd0, 1'b1));
      send_sample(sample_of(48'd30, 64'd1, 64'd5, 64'd0, 1'b1));
      send_sample(sample_of(48'd50, 64'hFFFF_FFFF_0000_0000, ones, 64'd0, 1'b1));
      send_sample(sample_of(48'd60, 64'd7, 64'd9, 64'd9, 1'b0));
      send_sample(sample_of(48'hFFFF_FFFF_FFFF, 64'd7, 64'd9, 64'd9, 1'b1));
   endtask

   task automatic test_interval_extremes();
      logic [cbps_pkg::INTERVAL_W-1:0] settings[4];
      settings = '{16'd0, 16'hFFFF, 16'd1, cbps_pkg::INTERVAL_W'($urandom)};
      foreach (settings[i]) begin
         set_min_interval(settings[i]);
         repeat (20) send_sample(next_load_sample());
      end
   endtask

   task automatic test_traffic_idling(input int idle_pct, input int stall_pct,
                                      input logic [cbps_pkg::INTERVAL_W-1:0] interval);
      set_min_interval(interval);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (100) send_sample(next_load_sample());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_interval_extremes();
      test_traffic_idling(0, 0, cbps_pkg::MIN_INTERVAL_RESET);
      test_traffic_idling(52, 0, 16'd50);
      test_traffic_idling(0, 52, 16'd1000);
      test_traffic_idling(27, 27, cbps_pkg::INTERVAL_W'($urandom_range(300, 0)));
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      drain_readings();
      $display("Summary: %0d samples over %0d interval settings, %0d results checked",
               samples_sent, interval_settings, readings_checked);
      $display("Result kinds: fresh %0d, short interval %0d, read failure %0d, %s %0d, %s %0d",
               kind_seen[cbps_pkg::KIND_FRESH], kind_seen[cbps_pkg::KIND_HELD_INTERVAL],
               kind_seen[cbps_pkg::KIND_HELD_READ], "baseline",
               kind_seen[cbps_pkg::KIND_BASELINE],
               "zero delta", kind_seen[cbps_pkg::KIND_HELD_ZERO]);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
